>>> rtl/dws_pkg.sv
// package: command and status codes and the control bundle for the deque cells
`timescale 1ns / 1ps
`default_nettype none
package dws_pkg;

	typedef enum logic [2:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_PUSH_BACK  = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_POP_BACK   = 3'd3,
		CMD_FIND       = 3'd4
	} dws_cmd_t;

	typedef enum logic [1:0] {
		STS_OK        = 2'd0,
		STS_FULL      = 2'd1,
		STS_EMPTY     = 2'd2,
		STS_NOT_FOUND = 2'd3
	} dws_status_t;

	typedef struct packed {
		logic push_front;
		logic push_back;
		logic pop_front;
		logic compare;
		logic scan;
	} dws_ctl_t;

endpackage
`default_nettype wire

>>> rtl/dws_req_if.sv
// interface: command channel of the deque
`timescale 1ns / 1ps
`default_nettype none
interface dws_req_if #(
	parameter int DATA_WIDTH = 32
);
	logic                         valid;
	logic                         ready;
	logic [2:0]                   cmd;
	logic signed [DATA_WIDTH-1:0] value;

	modport source (output valid, output cmd, output value, input ready);
	modport sink (input valid, input cmd, input value, output ready);
endinterface
`default_nettype wire

>>> rtl/dws_rsp_if.sv
// interface: result channel of the deque
`timescale 1ns / 1ps
`default_nettype none
interface dws_rsp_if #(
	parameter int POS_W = 6,
	parameter int OCC_W = 7
);
	logic             valid;
	logic             ready;
	logic [1:0]       status;
	logic [POS_W-1:0] position;
	logic [OCC_W-1:0] occupancy;

	modport source (output valid, output status, output position, output occupancy, input ready);
	modport sink (input valid, input status, input position, input occupancy, output ready);
endinterface
`default_nettype wire

>>> rtl/dws_cell.sv
// module: one deque cell holding the word at a fixed logical position and its match flag
`timescale 1ns / 1ps
`default_nettype none
module dws_cell
	import dws_pkg::*;
#(
	parameter int DATA_WIDTH = 32,
	parameter int OCC_W      = 7,
	parameter int IDX        = 0
) (
	input  wire logic                  clk,
	input  wire dws_ctl_t              ctl,
	input  wire logic [OCC_W-1:0]      count,
	input  wire logic [DATA_WIDTH-1:0] value,
	input  wire logic [DATA_WIDTH-1:0] prev_data,
	input  wire logic [DATA_WIDTH-1:0] next_data,
	input  wire logic                  next_match,
	output logic      [DATA_WIDTH-1:0] data,
	output logic                       match
);
	logic [DATA_WIDTH-1:0] data_q;
	logic                  match_q;
	logic                  at_tail;

	assign at_tail = (count == OCC_W'(IDX));

	always_ff @(posedge clk) begin
		if (ctl.push_front) begin
			data_q <= prev_data;
		end else if (ctl.pop_front) begin
			data_q <= next_data;
		end else if (ctl.push_back && at_tail) begin
			data_q <= value;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.compare) begin
			match_q <= (data_q == value);
		end else if (ctl.scan) begin
			match_q <= next_match;
		end
	end

	assign data  = data_q;
	assign match = match_q;
endmodule
`default_nettype wire

>>> rtl/dws_ctrl.sv
// module: command decoder, occupancy counter, find scan sequencer and result register
`timescale 1ns / 1ps
`default_nettype none
module dws_ctrl
	import dws_pkg::*;
#(
	parameter int DEPTH = 64
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	dws_req_if.sink                           req,
	dws_rsp_if.source                         rsp,
	input  wire logic                         head_match,
	output dws_ctl_t                          ctl,
	output logic      [$clog2(DEPTH+1)-1:0]   count
);
	localparam int POS_W = $clog2(DEPTH);
	localparam int OCC_W = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SCAN = 2'b10
	} dws_state_t;

	dws_state_t       st_q, st_n;
	logic [OCC_W-1:0] count_q, count_n;
	logic [OCC_W-1:0] pos_q, pos_n;
	logic             out_valid_q;
	dws_status_t      status_q, status_n;
	logic [POS_W-1:0] position_q, position_n;
	logic [OCC_W-1:0] occ_q;
	logic             emit;
	logic             acc;
	logic             full;
	logic             empty;

	assign full      = (count_q == OCC_W'(DEPTH));
	assign empty     = (count_q == '0);
	assign req.ready = (st_q == ST_IDLE) && (!out_valid_q || rsp.ready);
	assign acc       = req.valid && req.ready;

	always_comb begin
		ctl        = '0;
		st_n       = st_q;
		count_n    = count_q;
		pos_n      = pos_q;
		emit       = 1'b0;
		status_n   = STS_OK;
		position_n = '0;
		unique case (st_q)
			ST_IDLE: begin
				if (acc) begin
					emit = 1'b1;
					unique case (req.cmd)
						CMD_PUSH_FRONT: begin
							if (full) begin
								status_n = STS_FULL;
							end else begin
								ctl.push_front = 1'b1;
								count_n        = count_q + 1'b1;
							end
						end
						CMD_PUSH_BACK: begin
							if (full) begin
								status_n = STS_FULL;
							end else begin
								ctl.push_back = 1'b1;
								position_n    = count_q[POS_W-1:0];
								count_n       = count_q + 1'b1;
							end
						end
						CMD_POP_FRONT: begin
							if (empty) begin
								status_n = STS_EMPTY;
							end else begin
								ctl.pop_front = 1'b1;
								count_n       = count_q - 1'b1;
							end
						end
						CMD_POP_BACK: begin
							if (empty) begin
								status_n = STS_EMPTY;
							end else begin
								count_n = count_q - 1'b1;
							end
						end
						CMD_FIND: begin
							emit        = 1'b0;
							ctl.compare = 1'b1;
							pos_n       = '0;
							st_n        = ST_SCAN;
						end
						default: begin
						end
					endcase
				end
			end
			ST_SCAN: begin
				if (pos_q == count_q) begin
					emit     = 1'b1;
					status_n = STS_NOT_FOUND;
					st_n     = ST_IDLE;
				end else if (head_match) begin
					emit       = 1'b1;
					position_n = pos_q[POS_W-1:0];
					st_n       = ST_IDLE;
				end else begin
					ctl.scan = 1'b1;
					pos_n    = pos_q + 1'b1;
				end
			end
			default: begin
				st_n = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			count_q     <= '0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			st_q    <= st_n;
			count_q <= count_n;
			pos_q   <= pos_n;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			status_q   <= status_n;
			position_q <= position_n;
			occ_q      <= count_n;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.status    = status_q;
	assign rsp.position  = position_q;
	assign rsp.occupancy = occ_q;
	assign count         = count_q;

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= OCC_W'(DEPTH))
		else $error("occupancy above capacity");

	a_scan_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_SCAN) |-> !out_valid_q)
		else $error("result register busy during find scan");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_SCAN) |-> (pos_q <= count_q))
		else $error("scan position beyond occupancy");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && !full && (req.cmd == CMD_PUSH_FRONT || req.cmd == CMD_PUSH_BACK))
		|=> (count_q == $past(count_q) + 1'b1))
		else $error("push transfer did not grow occupancy");

	a_scan_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_SCAN) |=> $stable(count_q))
		else $error("occupancy changed during find scan");
`endif
endmodule
`default_nettype wire

>>> rtl/deque_with_search_top.sv
// Bounded double-ended queue of signed words with search by value.
// Channel req (sink): cmd and value; a transfer happens when valid and ready are high.
// Channel rsp (source): status, position and occupancy, one result per command.
// The entries sit in a row of DEPTH cells ordered by logical position: a push at
// the front shifts the row one cell back, a pop at the front shifts it forward,
// a push at the back writes the cell at the current occupancy.
// Push and pop commands: the result is registered and shown on rsp in the cycle
// after the command transfer; one such command per cycle while rsp drains.
// Find: the cells compare against the value in the transfer cycle, then the
// match flags are shifted towards the front one cell per cycle and counted
// until the head flag shows a match (the count is its position) or reaches the occupancy.
// req is not ready during a find scan, nor while a result waits and rsp is stalled;
// a stalled result holds its payload until taken.
// Reset empties the queue; cell contents are not cleared and are never read
// unless held.
`timescale 1ns / 1ps
`default_nettype none
module deque_with_search_top
	import dws_pkg::*;
#(
	parameter int DEPTH      = 64,
	parameter int DATA_WIDTH = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	dws_req_if.sink   req,
	dws_rsp_if.source rsp
);
	localparam int OCC_W = $clog2(DEPTH + 1);

	dws_ctl_t              ctl;
	logic [OCC_W-1:0]      count;
	logic [DATA_WIDTH-1:0] data_w  [DEPTH];
	logic                  match_w [DEPTH];

	dws_ctrl #(
		.DEPTH (DEPTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.rsp        (rsp),
		.head_match (match_w[0]),
		.ctl        (ctl),
		.count      (count)
	);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] prev_d;
		logic [DATA_WIDTH-1:0] next_d;
		logic                  next_m;

		if (i == 0) begin : g_first
			assign prev_d = req.value;
		end else begin : g_mid
			assign prev_d = data_w[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign next_d = data_w[i];
			assign next_m = 1'b0;
		end else begin : g_inner
			assign next_d = data_w[i+1];
			assign next_m = match_w[i+1];
		end

		dws_cell #(
			.DATA_WIDTH (DATA_WIDTH),
			.OCC_W      (OCC_W),
			.IDX        (i)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.count      (count),
			.value      (req.value),
			.prev_data  (prev_d),
			.next_data  (next_d),
			.next_match (next_m),
			.data       (data_w[i]),
			.match      (match_w[i])
		);
	end
endmodule
`default_nettype wire

>>> tb/tb_deque_with_search_top.sv
// testbench: deque_with_search_top checked against a behavioural deque predictor
`timescale 1ns / 1ps
module tb_deque_with_search_top;
	import dws_pkg::*;

	localparam int DEPTH          = 64;
	localparam int DATA_WIDTH     = 32;
	localparam int HOLD_OFF_TICKS = 150;
	localparam int DRAIN_TICKS    = 80;
	localparam int STALL_LIMIT    = 2000;
	localparam int ITEMS_PER_PASS = 217;
	localparam int SEGMENT_LEN    = 90;

	localparam logic [2:0] CMD_RSVD_5 = 3'd5;
	localparam logic [2:0] CMD_RSVD_6 = 3'd6;
	localparam logic [2:0] CMD_RSVD_7 = 3'd7;

	typedef enum int {
		MIX_FILL,
		MIX_BALANCED,
		MIX_DRAIN
	} traffic_mix_t;

	typedef struct packed {
		dws_status_t status;
		logic [5:0]  position;
		logic [6:0]  occupancy;
	} deque_result_t;

	typedef struct packed {
		logic [2:0]    cmd;
		logic [31:0]   value;
		bit            typed;
		deque_result_t result;
	} directed_row_t;

	localparam logic [31:0] WORD_POOL [8] = '{
		32'h0000_0000, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000,
		32'h0000_0001, 32'h5555_5555, 32'haaaa_aaaa, 32'h0000_0007
	};

	directed_row_t directed_rows [26] = '{
		'{CMD_POP_FRONT,  32'h0000_0000, 1'b1, '{STS_EMPTY,     6'd0, 7'd0}},
		'{CMD_POP_BACK,   32'h0000_0000, 1'b1, '{STS_EMPTY,     6'd0, 7'd0}},
		'{CMD_FIND,       32'h0000_0000, 1'b1, '{STS_NOT_FOUND, 6'd0, 7'd0}},
		'{CMD_PUSH_BACK,  32'h7fff_ffff, 1'b1, '{STS_OK,        6'd0, 7'd1}},
		'{CMD_PUSH_FRONT, 32'h8000_0000, 1'b1, '{STS_OK,        6'd0, 7'd2}},
		'{CMD_PUSH_BACK,  32'h0000_0000, 1'b1, '{STS_OK,        6'd2, 7'd3}},
		'{CMD_PUSH_BACK,  32'hffff_ffff, 1'b1, '{STS_OK,        6'd3, 7'd4}},
		'{CMD_PUSH_FRONT, 32'h7fff_ffff, 1'b1, '{STS_OK,        6'd0, 7'd5}},
		'{CMD_FIND,       32'h7fff_ffff, 1'b1, '{STS_OK,        6'd0, 7'd5}},
		'{CMD_FIND,       32'h8000_0000, 1'b1, '{STS_OK,        6'd1, 7'd5}},
		'{CMD_FIND,       32'hffff_ffff, 1'b1, '{STS_OK,        6'd4, 7'd5}},
		'{CMD_FIND,       32'h1234_5678, 1'b1, '{STS_NOT_FOUND, 6'd0, 7'd5}},
		'{CMD_RSVD_5,     32'hffff_ffff, 1'b1, '{STS_OK,        6'd0, 7'd5}},
		'{CMD_RSVD_6,     32'h0000_0000, 1'b1, '{STS_OK,        6'd0, 7'd5}},
		'{CMD_RSVD_7,     32'h0000_0000, 1'b1, '{STS_OK,        6'd0, 7'd5}},
		'{CMD_POP_FRONT,  32'h0000_0000, 1'b1, '{STS_OK,        6'd0, 7'd4}},
		'{CMD_FIND,       32'h7fff_ffff, 1'b0, '{STS_OK,        6'd0, 7'd0}},
		'{CMD_POP_BACK,   32'hffff_ffff, 1'b1, '{STS_OK,        6'd0, 7'd3}},
		'{CMD_FIND,       32'hffff_ffff, 1'b1, '{STS_NOT_FOUND, 6'd0, 7'd3}},
		'{CMD_PUSH_FRONT, 32'h0000_0000, 1'b0, '{STS_OK,        6'd0, 7'd0}},
		'{CMD_FIND,       32'h0000_0000, 1'b0, '{STS_OK,        6'd0, 7'd0}},
		'{CMD_POP_BACK,   32'h0000_0000, 1'b0, '{STS_OK,        6'd0, 7'd0}},
		'{CMD_POP_BACK,   32'h0000_0000, 1'b0, '{STS_OK,        6'd0, 7'd0}},
		'{CMD_POP_FRONT,  32'h0000_0000, 1'b0, '{STS_OK,        6'd0, 7'd0}},
		'{CMD_POP_FRONT,  32'h0000_0000, 1'b0, '{STS_OK,        6'd0, 7'd0}},
		'{CMD_POP_BACK,   32'h0000_0000, 1'b1, '{STS_EMPTY,     6'd0, 7'd0}}
	};

	logic clk;
	logic arst_n;

	dws_req_if #(.DATA_WIDTH(DATA_WIDTH)) req_ch ();
	dws_rsp_if #(.POS_W(6), .OCC_W(7)) rsp_ch ();

	deque_with_search_top #(
		.DEPTH(DEPTH),
		.DATA_WIDTH(DATA_WIDTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch.sink),
		.rsp(rsp_ch.source)
	);

	// predictor state: ring of words, front index and fill level
	logic [31:0]   cells [DEPTH];
	int unsigned   head_ptr;
	int unsigned   held;
	deque_result_t pending_results [$];

	int tx_idle_pct;
	int rx_idle_pct;
	bit hold_off_pending;
	int error_count;
	int quiet_cycles;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic deque_result_t apply_command(logic [2:0] c, logic [31:0] v);
		deque_result_t r;
		r.status   = STS_OK;
		r.position = '0;
		case (c)
			CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
				if (held >= DEPTH) begin
					r.status = STS_FULL;
				end else if (c == CMD_PUSH_FRONT) begin
					head_ptr = (head_ptr + DEPTH - 1) % DEPTH;
					cells[head_ptr] = v;
					held++;
				end else begin
					cells[(head_ptr + held) % DEPTH] = v;
					r.position = held[5:0];
					held++;
				end
			end
			CMD_POP_FRONT, CMD_POP_BACK: begin
				if (held == 0) begin
					r.status = STS_EMPTY;
				end else begin
					if (c == CMD_POP_FRONT)
						head_ptr = (head_ptr + 1) % DEPTH;
					held--;
				end
			end
			CMD_FIND: begin
				r.status = STS_NOT_FOUND;
				for (int i = 0; i < held; i++) begin
					if (cells[(head_ptr + i) % DEPTH] == v) begin
						r.status   = STS_OK;
						r.position = i[5:0];
						break;
					end
				end
			end
			default: ;
		endcase
		r.occupancy = held[6:0];
		return r;
	endfunction

	function automatic logic [31:0] random_word();
		if ($urandom_range(99) < 40)
			return WORD_POOL[$urandom_range(7)];
		return $urandom;
	endfunction

	function automatic logic [2:0] pick_cmd(traffic_mix_t mix);
		int r;
		int push_lim;
		int pop_lim;
		r = $urandom_range(99);
		case (mix)
			MIX_FILL: begin
				push_lim = 80;
				pop_lim  = 85;
			end
			MIX_DRAIN: begin
				push_lim = 5;
				pop_lim  = 85;
			end
			default: begin
				push_lim = 35;
				pop_lim  = 70;
			end
		endcase
		if (r < push_lim)
			return $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
		if (r < pop_lim)
			return $urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT;
		if (r < 97)
			return CMD_FIND;
		case ($urandom_range(2))
			0: return CMD_RSVD_5;
			1: return CMD_RSVD_6;
			default: return CMD_RSVD_7;
		endcase
	endfunction

	// called at a rising edge; returns at the edge of the transfer
	task automatic issue(input logic [2:0] c, input logic [31:0] v, input bit typed,
			input deque_result_t typed_r);
		deque_result_t r;
		while ($urandom_range(99) < tx_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.cmd   <= c;
		req_ch.value <= v;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		r = apply_command(c, v);
		pending_results.push_back(typed ? typed_r : r);
	endtask

	// receiver: random back-pressure plus one long hold-off on request
	initial begin
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_pending) begin
				hold_off_pending = 1'b0;
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_OFF_TICKS - 1) @(posedge clk);
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	always @(posedge clk) begin : result_check
		deque_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				error_count++;
				$display("%0t: unexpected result status=%0d position=%0d occupancy=%0d",
					$time, rsp_ch.status, rsp_ch.position, rsp_ch.occupancy);
			end else begin
				want = pending_results.pop_front();
				if (rsp_ch.status !== want.status || rsp_ch.position !== want.position ||
						rsp_ch.occupancy !== want.occupancy) begin
					error_count++;
					$display("%0t: expected status=%0d position=%0d occupancy=%0d, got status=%0d position=%0d occupancy=%0d",
						$time, want.status, want.position, want.occupancy,
						rsp_ch.status, rsp_ch.position, rsp_ch.occupancy);
				end
			end
		end
	end

	// watchdog on cycles with no transfer on either channel
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin : stimulus
		deque_result_t no_result;
		traffic_mix_t  mix;
		logic [2:0]    c;
		logic [31:0]   v;
		int            n;

		no_result        = '0;
		n                = 0;
		tx_idle_pct      = 0;
		rx_idle_pct      = 0;
		hold_off_pending = 1'b0;
		error_count      = 0;
		quiet_cycles     = 0;
		head_ptr         = 0;
		held             = 0;
		arst_n       <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.cmd   <= CMD_PUSH_FRONT;
		req_ch.value <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 23;
		rx_idle_pct = 47;
		foreach (directed_rows[i])
			issue(directed_rows[i].cmd, directed_rows[i].value, directed_rows[i].typed,
				directed_rows[i].result);

		for (int pass = 0; pass < 3; pass++) begin
			case (pass)
				0: begin
					tx_idle_pct = 23;
					rx_idle_pct = 47;
				end
				1: begin
					tx_idle_pct = 47;
					rx_idle_pct = 23;
					hold_off_pending = 1'b1;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			for (int k = 0; k < ITEMS_PER_PASS; k++) begin
				case ((n / SEGMENT_LEN) % 4)
					0: mix = MIX_FILL;
					2: mix = MIX_DRAIN;
					default: mix = MIX_BALANCED;
				endcase
				c = pick_cmd(mix);
				if (c == CMD_FIND && held > 0 && $urandom_range(99) < 75)
					v = cells[(head_ptr + $urandom_range(held - 1)) % DEPTH];
				else
					v = random_word();
				issue(c, v, 1'b0, no_result);
				n++;
			end
			// sender pause until every result is back
			req_ch.valid <= 1'b0;
			while (pending_results.size() != 0)
				@(posedge clk);
		end

		repeat (DRAIN_TICKS) @(posedge clk);
		if (pending_results.size() != 0) begin
			error_count++;
			$display("%0t: %0d results never arrived", $time, pending_results.size());
		end
		if (error_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

>>> sim.f
rtl/dws_pkg.sv
rtl/dws_req_if.sv
rtl/dws_rsp_if.sv
rtl/dws_cell.sv
rtl/dws_ctrl.sv
rtl/deque_with_search_top.sv
tb/tb_deque_with_search_top.sv
